// ===== sv/cslu_pkg.sv =====
// Package for the C string literal unescaper.
// Holds the input and result word types, the result run type, kind codes
// and the character constants used by the decoder. No dependencies.
package cslu_pkg;

    localparam int RUN_MAX = 3;
    localparam int CONSUMED_WIDTH = 16;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_CLOSED   = 2'd1;
    localparam logic [1:0] KIND_BAD_OPEN = 2'd2;
    localparam logic [1:0] KIND_UNCLOSED = 2'd3;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;

    localparam logic [7:0] ESC_BEL = 8'h07;
    localparam logic [7:0] ESC_BS  = 8'h08;
    localparam logic [7:0] ESC_ESC = 8'h1B;
    localparam logic [7:0] ESC_FF  = 8'h0C;
    localparam logic [7:0] ESC_LF  = 8'h0A;
    localparam logic [7:0] ESC_CR  = 8'h0D;
    localparam logic [7:0] ESC_TAB = 8'h09;
    localparam logic [7:0] ESC_VT  = 8'h0B;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]                data_byte;
        logic [1:0]                kind;
        logic [CONSUMED_WIDTH-1:0] consumed;
        logic                      range_error;
        logic                      last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [1:0]                   count;
        t_out_word [RUN_MAX-1:0]      res;
    } t_run;

endpackage

// ===== sv/cslu_core.sv =====
// Parser state and single-pass decode of one registered input byte.
// Produces the run of up to three result words for that byte.
// Depends on cslu_pkg.
module cslu_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  cslu_pkg::t_in_word i_word,
    output cslu_pkg::t_run    o_run
);
    import cslu_pkg::*;

    localparam int EXT_WIDTH = (COUNT_WIDTH > CONSUMED_WIDTH) ? COUNT_WIDTH : CONSUMED_WIDTH;

    typedef enum logic [2:0] {
        M_IDLE, M_READ, M_ESC, M_HEX1, M_HEX2, M_OCT, M_HALT
    } t_mode;

    t_mode                  r_mode, n_mode, c_mode;
    logic                   r_single, n_single, c_single;
    logic [8:0]             r_val, n_val, c_val;
    logic [1:0]             r_dig, n_dig, c_dig;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt, c_cnt;

    logic [7:0]     b;
    logic           live;
    logic           as_text;
    logic           hv_ok;
    logic [3:0]     hv;
    logic           od_ok;
    logic [8:0]     oct_val;
    logic [1:0]     oct_dig;
    logic [7:0]     quote;
    logic [EXT_WIDTH-1:0]      cnt_ext;
    logic [CONSUMED_WIDTH-1:0] consumed;
    logic [2:0]     slot_vld;
    t_out_word      slot [RUN_MAX];
    logic [1:0]     k;

    always_comb begin
        b        = i_word.in_byte;
        c_mode   = i_word.first_byte ? M_IDLE : r_mode;
        c_single = i_word.first_byte ? 1'b0 : r_single;
        c_val    = i_word.first_byte ? '0 : r_val;
        c_dig    = i_word.first_byte ? '0 : r_dig;
        c_cnt    = i_word.first_byte ? '0 : r_cnt;

        n_mode   = c_mode;
        n_single = c_single;
        n_val    = c_val;
        n_dig    = c_dig;
        n_cnt    = c_cnt;

        live     = (c_mode != M_HALT) && (c_mode <= M_OCT);
        as_text  = 1'b0;
        slot_vld = '0;
        for (int i = 0; i < RUN_MAX; i++) begin
            slot[i] = '0;
        end

        priority if (b >= 8'h30 && b <= 8'h39) begin
            hv_ok = 1'b1;
            hv    = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            hv_ok = 1'b1;
            hv    = b[3:0] + 4'd9;
        end else begin
            hv_ok = 1'b0;
            hv    = '0;
        end
        od_ok   = (b >= 8'h30) && (b <= 8'h37);
        oct_val = {c_val[5:0], b[2:0]};
        oct_dig = c_dig + 2'd1;
        quote   = c_single ? CH_SQUOTE : CH_DQUOTE;

        if (live) begin
            n_cnt = (c_cnt == '1) ? c_cnt : c_cnt + 1'b1;
            unique case (c_mode)
                M_IDLE: begin
                    if (b == CH_SQUOTE || b == CH_DQUOTE) begin
                        n_single = (b == CH_SQUOTE);
                        n_mode   = M_READ;
                    end else begin
                        slot_vld[0]  = 1'b1;
                        slot[0].kind = KIND_BAD_OPEN;
                        n_mode       = M_HALT;
                    end
                end
                M_READ: begin
                    as_text = 1'b1;
                end
                M_ESC: begin
                    n_mode      = M_READ;
                    slot_vld[0] = 1'b1;
                    unique case (b)
                        CH_A: slot[0].data_byte = ESC_BEL;
                        CH_B: slot[0].data_byte = ESC_BS;
                        CH_E: slot[0].data_byte = ESC_ESC;
                        CH_F: slot[0].data_byte = ESC_FF;
                        CH_N: slot[0].data_byte = ESC_LF;
                        CH_R: slot[0].data_byte = ESC_CR;
                        CH_T: slot[0].data_byte = ESC_TAB;
                        CH_V: slot[0].data_byte = ESC_VT;
                        CH_X: begin
                            slot_vld[0] = 1'b0;
                            n_val       = '0;
                            n_dig       = '0;
                            n_mode      = M_HEX1;
                        end
                        default: begin
                            if (od_ok) begin
                                slot_vld[0] = 1'b0;
                                n_val       = {6'd0, b[2:0]};
                                n_dig       = 2'd1;
                                n_mode      = M_OCT;
                            end else begin
                                slot[0].data_byte = b;
                            end
                        end
                    endcase
                end
                M_HEX1: begin
                    if (hv_ok) begin
                        n_val  = {5'd0, hv};
                        n_dig  = 2'd1;
                        n_mode = M_HEX2;
                    end else begin
                        n_mode  = M_READ;
                        as_text = 1'b1;
                    end
                end
                M_HEX2: begin
                    n_mode      = M_READ;
                    slot_vld[0] = 1'b1;
                    if (hv_ok) begin
                        slot[0].data_byte = {c_val[3:0], hv};
                    end else begin
                        slot[0].data_byte = c_val[7:0];
                        as_text           = 1'b1;
                    end
                end
                M_OCT: begin
                    if (od_ok) begin
                        n_val = oct_val;
                        n_dig = oct_dig;
                        if (oct_dig == 2'd3 || oct_dig == 2'd0) begin
                            slot_vld[0]         = 1'b1;
                            slot[0].data_byte   = oct_val[7:0];
                            slot[0].range_error = oct_val[8];
                            n_mode              = M_READ;
                        end
                    end else begin
                        slot_vld[0]       = 1'b1;
                        slot[0].data_byte = c_val[7:0];
                        n_mode            = M_READ;
                        as_text           = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (as_text) begin
                priority if (b == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else if (b == quote) begin
                    slot_vld[1]  = 1'b1;
                    slot[1].kind = KIND_CLOSED;
                    n_mode       = M_HALT;
                end else begin
                    slot_vld[1]       = 1'b1;
                    slot[1].data_byte = b;
                end
            end

            if (i_word.final_byte && n_mode != M_HALT) begin
                slot_vld[2]  = 1'b1;
                slot[2].kind = KIND_UNCLOSED;
                n_mode       = M_HALT;
            end
        end

        cnt_ext  = EXT_WIDTH'(n_cnt);
        consumed = (cnt_ext > EXT_WIDTH'({CONSUMED_WIDTH{1'b1}})) ?
                   {CONSUMED_WIDTH{1'b1}} : cnt_ext[CONSUMED_WIDTH-1:0];
        for (int i = 0; i < RUN_MAX; i++) begin
            if (slot[i].kind != KIND_DATA) begin
                slot[i].consumed = consumed;
            end
        end

        o_run = '0;
        k     = '0;
        for (int i = 0; i < RUN_MAX; i++) begin
            if (slot_vld[i]) begin
                o_run.res[k] = slot[i];
                k            = k + 2'd1;
            end
        end
        o_run.count = k;
        if (k != 2'd0) begin
            o_run.res[k - 2'd1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_single <= 1'b0;
            r_val    <= '0;
            r_dig    <= '0;
            r_cnt    <= '0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_single <= n_single;
            r_val    <= n_val;
            r_dig    <= n_dig;
            r_cnt    <= n_cnt;
        end
    end

    a_bad_open_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_run.count != 2'd0 && o_run.res[0].kind == KIND_BAD_OPEN)
        |-> o_run.count == 2'd1)
        else $error("bad opening result shares its run");

    a_halt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_mode == M_HALT && !i_word.first_byte)
        |=> (r_cnt == $past(r_cnt)) && (r_mode == M_HALT))
        else $error("halted parser advanced without restart");

endmodule

// ===== sv/cslu_emit.sv =====
// Result buffer: loads one run of up to three words, drains one per cycle unless stalled.
// Its head register drives the output channel. Depends on cslu_pkg.
module cslu_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  cslu_pkg::t_run     i_run,
    output logic               o_can_load,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cslu_pkg::t_out_word o_out_word
);
    import cslu_pkg::*;

    t_out_word  r_res [RUN_MAX];
    logic [1:0] r_cnt;
    logic       pop;
    logic       load;

    assign pop        = (r_cnt != 2'd0) && !i_out_stall;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign load       = i_load && o_can_load;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_word  = r_res[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= i_run.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < RUN_MAX; i++) begin
                r_res[i] <= i_run.res[i];
            end
        end else if (pop) begin
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                r_res[i] <= r_res[i + 1];
            end
        end
    end

    a_last_on_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_res[0].last_of_run)
        else $error("final word of run lacks last_of_run");

    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !r_res[0].last_of_run)
        else $error("last_of_run set before end of run");

endmodule

// ===== sv/c_string_literal_unescaper_unit.sv =====
// C string literal unescaper, top level.
// Input register, decode core and result buffer. Depends on cslu_pkg,
// cslu_core and cslu_emit.
//
// Input channel: one raw byte per word, with first_byte restarting the parser
// and final_byte marking the end of the buffer. Output channel: result words
// carrying a decoded data byte, a close with its consumed length, or an
// error (bad opening quote, buffer ended unclosed); last_of_run marks the
// final word that a given input byte causes.
// Path: input register, decode core, then the result buffer head to the output.
// Throughput: one input byte per cycle while each byte yields at most one
// result and the output is not stalled; a byte yielding several words holds
// the input until the single-word output port drains the result buffer.
// Bytes after a close or error yield no words and still pass at one per cycle.
// Reset: synchronous, active low; the parser returns to awaiting an opening
// quote with a zero byte count, and both channels empty.
// Stall: a stalled output holds its word; the input register keeps taking
// one more byte, then o_in_stall rises until the buffer can take its run.
module c_string_literal_unescaper_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cslu_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cslu_pkg::t_out_word o_out_word
);
    import cslu_pkg::*;

    logic     r_in_valid;
    t_in_word r_in;
    logic     can_load;
    logic     take;
    t_run     run;

    assign take       = r_in_valid && can_load;
    assign o_in_stall = r_in_valid && !can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    cslu_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (r_in),
        .o_run   (run)
    );

    cslu_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_in_valid),
        .i_run       (run),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== tb/tb_c_string_literal_unescaper_unit.sv =====
// Self-checking testbench for c_string_literal_unescaper_unit: directed literals,
// random well-formed and broken literals and back-pressure.
// Depends on cslu_pkg and the unit; predicts result words with its own decoder.
module tb_c_string_literal_unescaper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cslu_pkg::*;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_7  = 8'h37;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    localparam int WATCH_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 250;
    localparam int RANDOM_ITEMS = 240;
    localparam int TAIL_CYCLES  = 8;
    localparam int SHOW_LIMIT   = 10;

    typedef enum logic [2:0] {
        PM_IDLE,
        PM_TEXT,
        PM_ESC,
        PM_HEX1,
        PM_HEX2,
        PM_OCT,
        PM_DONE
    } t_parse_mode;

    class unescape_tracker;
        t_out_word                 awaited_words[$];
        t_out_word                 run_words[$];
        int                        bad_words;
        t_parse_mode               mode;
        logic                      quote_single;
        logic [8:0]                esc_val;
        logic [1:0]                digits;
        logic [CONSUMED_WIDTH-1:0] count;

        function new();
            bad_words = 0;
            restart();
        endfunction

        function void restart();
            mode = PM_IDLE;
            quote_single = 1'b0;
            esc_val = '0;
            digits = '0;
            count = '0;
        endfunction

        function void add(logic [7:0] data, logic [1:0] kind, logic range_err);
            t_out_word w;
            w.data_byte = (kind == KIND_DATA) ? data : 8'h00;
            w.kind = kind;
            w.consumed = (kind == KIND_DATA) ? '0 : count;
            w.range_error = range_err;
            w.last_of_run = 1'b0;
            run_words = {run_words, w};
        endfunction

        function int hex_digit(logic [7:0] b);
            if (b >= CH_0 && b <= CH_9) return b - CH_0;
            if (b >= CH_A && b <= CH_F) return b - CH_A + 10;
            if (b >= CH_UA && b <= CH_UF) return b - CH_UA + 10;
            return -1;
        endfunction

        function bit is_octal(logic [7:0] b);
            return b >= CH_0 && b <= CH_7;
        endfunction

        function void take_byte(t_in_word w);
            logic [7:0] b;
            logic [7:0] q;
            bit         as_text;
            int         h;
            t_out_word  r;
            b = w.in_byte;
            as_text = 1'b0;
            run_words.delete();
            if (w.first_byte) restart();
            if (mode == PM_DONE) return;
            if (count != '1) count++;
            case (mode)
                PM_IDLE: begin
                    if (b == CH_SQUOTE || b == CH_DQUOTE) begin
                        quote_single = (b == CH_SQUOTE);
                        mode = PM_TEXT;
                    end else begin
                        add(8'h00, KIND_BAD_OPEN, 1'b0);
                        mode = PM_DONE;
                    end
                end
                PM_TEXT: as_text = 1'b1;
                PM_ESC: begin
                    mode = PM_TEXT;
                    case (b)
                        CH_A: add(ESC_BEL, KIND_DATA, 1'b0);
                        CH_B: add(ESC_BS, KIND_DATA, 1'b0);
                        CH_E: add(ESC_ESC, KIND_DATA, 1'b0);
                        CH_F: add(ESC_FF, KIND_DATA, 1'b0);
                        CH_N: add(ESC_LF, KIND_DATA, 1'b0);
                        CH_R: add(ESC_CR, KIND_DATA, 1'b0);
                        CH_T: add(ESC_TAB, KIND_DATA, 1'b0);
                        CH_V: add(ESC_VT, KIND_DATA, 1'b0);
                        CH_X: begin
                            esc_val = '0;
                            digits = '0;
                            mode = PM_HEX1;
                        end
                        default: begin
                            if (is_octal(b)) begin
                                esc_val = {6'd0, b[2:0]};
                                digits = 2'd1;
                                mode = PM_OCT;
                            end else begin
                                add(b, KIND_DATA, 1'b0);
                            end
                        end
                    endcase
                end
                PM_HEX1: begin
                    h = hex_digit(b);
                    if (h >= 0) begin
                        esc_val = h[8:0];
                        digits = 2'd1;
                        mode = PM_HEX2;
                    end else begin
                        mode = PM_TEXT;
                        as_text = 1'b1;
                    end
                end
                PM_HEX2: begin
                    h = hex_digit(b);
                    mode = PM_TEXT;
                    if (h >= 0) begin
                        add({esc_val[3:0], h[3:0]}, KIND_DATA, 1'b0);
                    end else begin
                        add(esc_val[7:0], KIND_DATA, 1'b0);
                        as_text = 1'b1;
                    end
                end
                PM_OCT: begin
                    if (is_octal(b)) begin
                        esc_val = (esc_val << 3) + {6'd0, b[2:0]};
                        digits = digits + 2'd1;
                        if (digits == 2'd3 || digits == 2'd0) begin
                            add(esc_val[7:0], KIND_DATA, esc_val[8]);
                            mode = PM_TEXT;
                        end
                    end else begin
                        add(esc_val[7:0], KIND_DATA, 1'b0);
                        mode = PM_TEXT;
                        as_text = 1'b1;
                    end
                end
                default: ;
            endcase
            if (as_text) begin
                q = quote_single ? CH_SQUOTE : CH_DQUOTE;
                if (b == CH_BSLASH) begin
                    mode = PM_ESC;
                end else if (b == q) begin
                    add(8'h00, KIND_CLOSED, 1'b0);
                    mode = PM_DONE;
                end else begin
                    add(b, KIND_DATA, 1'b0);
                end
            end
            if (w.final_byte && mode != PM_DONE) begin
                add(8'h00, KIND_UNCLOSED, 1'b0);
                mode = PM_DONE;
            end
            foreach (run_words[i]) begin
                r = run_words[i];
                r.last_of_run = (i == run_words.size() - 1);
                awaited_words = {awaited_words, r};
            end
        endfunction

        function void match_word(t_out_word got);
            t_out_word want;
            if (awaited_words.size() == 0) begin
                bad_words++;
                if (bad_words <= SHOW_LIMIT)
                    $display("unexpected word: data=%h kind=%0d consumed=%0d range=%b last=%b",
                             got.data_byte, got.kind, got.consumed, got.range_error,
                             got.last_of_run);
                return;
            end
            want = awaited_words.pop_front();
            if (got.data_byte !== want.data_byte || got.kind !== want.kind ||
                got.consumed !== want.consumed || got.range_error !== want.range_error ||
                got.last_of_run !== want.last_of_run) begin
                bad_words++;
                if (bad_words <= SHOW_LIMIT)
                    $display({"word mismatch: expected data=%h kind=%0d consumed=%0d range=%b ",
                              "last=%b, got data=%h kind=%0d consumed=%0d range=%b last=%b"},
                             want.data_byte, want.kind, want.consumed, want.range_error,
                             want.last_of_run, got.data_byte, got.kind, got.consumed,
                             got.range_error, got.last_of_run);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    bit no_idle;
    bit hold_req;
    int burst_left;
    int items_sent;

    unescape_tracker tracker = new();

    c_string_literal_unescaper_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.match_word(o_out_word);
    end

    // hold off each word for a random count, or for a long stretch on request
    initial begin : result_sink
        int n;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCH_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic drive_byte(input logic [7:0] b, input logic first, input logic fin);
        t_in_word w;
        int       gap;
        w.in_byte = b;
        w.first_byte = first;
        w.final_byte = fin;
        gap = (no_idle || burst_left > 0) ? 0 : $urandom_range(0, 18);
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_byte(w);
        items_sent++;
    endtask

    task automatic drive_text(input string s, input bit first, input bit fin);
        for (int i = 0; i < s.len(); i++)
            drive_byte(s[i], first && i == 0, fin && i == s.len() - 1);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.awaited_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic drive_random_literal();
        logic [7:0] lit[$];
        logic [7:0] q;
        logic [7:0] r;
        int         ending;
        bit         fin;
        string      hex_set;
        hex_set = "0123456789abcdefABCDEF";
        fin = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) lit = {lit, 8'($urandom_range(0, 255))};
            fin = 1'($urandom_range(0, 1));
        end else begin
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            lit = {lit, q};
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 6))
                    0, 1: begin
                        r = 8'($urandom_range(0, 255));
                        if (r == q || r == CH_BSLASH) r = CH_N;
                        lit = {lit, r};
                    end
                    2: begin
                        case ($urandom_range(0, 7))
                            0: r = CH_A;
                            1: r = CH_B;
                            2: r = CH_E;
                            3: r = CH_F;
                            4: r = CH_N;
                            5: r = CH_R;
                            6: r = CH_T;
                            default: r = CH_V;
                        endcase
                        lit = {lit, CH_BSLASH, r};
                    end
                    3: begin
                        lit = {lit, CH_BSLASH, 8'($urandom_range(0, 255))};
                    end
                    4: begin
                        lit = {lit, CH_BSLASH, CH_X};
                        repeat ($urandom_range(0, 2))
                            lit = {lit, 8'(hex_set[$urandom_range(0, 21)])};
                    end
                    5: begin
                        lit = {lit, CH_BSLASH};
                        repeat ($urandom_range(1, 3))
                            lit = {lit, CH_0 + 8'($urandom_range(0, 7))};
                    end
                    default: begin
                        lit = {lit, CH_BSLASH, q};
                    end
                endcase
            end
            ending = $urandom_range(0, 9);
            if (ending <= 6) begin
                lit = {lit, q};
                fin = ($urandom_range(0, 3) == 0);
            end else if (ending == 7) begin
                fin = 1'b1;
            end else if (ending == 9) begin
                lit = {lit, q};
                repeat ($urandom_range(1, 3)) lit = {lit, 8'($urandom_range(0, 255))};
                fin = 1'($urandom_range(0, 1));
            end
        end
        no_idle = ($urandom_range(0, 3) == 0);
        foreach (lit[i]) drive_byte(lit[i], i == 0, fin && i == lit.size() - 1);
    endtask

    initial begin : stimulus
        int  start;
        bit  held;
        bit  paused;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        burst_left = 0;
        items_sent = 0;
        held = 1'b0;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opener taken without first_byte, short octal, empty hex, short hex before close
        drive_text("'\\1A\\xg\\x5'", 1'b0, 1'b0);
        // two hex digits with both cases, octal above 255, close on the final byte
        drive_text("\"\\xaF\\777\"", 1'b1, 1'b1);
        // bad opener, then a byte dropped after the error
        drive_byte(8'hFF, 1'b1, 1'b0);
        drive_byte(8'h00, 1'b0, 1'b0);
        // restart while open, then an escape left pending on the final byte
        drive_text("\"n", 1'b1, 1'b0);
        drive_text("'\\", 1'b1, 1'b1);

        start = items_sent;
        while (items_sent < start + RANDOM_ITEMS) begin
            if (!held && items_sent >= start + 90) begin
                held = 1'b1;
                hold_req = 1'b1;
                burst_left = 40;
            end
            if (!paused && items_sent >= start + 180) begin
                paused = 1'b1;
                drain_results();
            end
            drive_random_literal();
        end
        drain_results();

        if (tracker.bad_words == 0 && tracker.awaited_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
